@@ design/sha1s_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1s_pkg: shared types and constants for the streaming SHA-1 hasher
// Item structs for both channels, initial chaining values, round constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } out_item_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'b10000000;

    localparam logic [6:0] ROUND_F1   = 7'd20;
    localparam logic [6:0] ROUND_F2   = 7'd40;
    localparam logic [6:0] ROUND_F3   = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    localparam logic [5:0] POS_LAST     = 6'd63;
    localparam logic [5:0] POS_LEN_NEXT = 6'd55;

endpackage

`default_nettype wire

@@ design/sha1_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha1_stream_hasher: streaming SHA-1, one message byte per item
// Byte input channel, digest output channel, one round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_item): each item carries data_byte,
//   byte_present and end_of_message. A present byte is appended to the
//   message; end_of_message closes it (with or without a byte of its own).
//   Output channel (out_valid/out_ready/out_item): one item per message,
//   the 160-bit digest as five big-endian words, digest_word0 first.
// Operation:
//   A byte that does not fill a block is only stored. The 64th byte of a
//   block starts a compression: 80 rounds on the single round unit, then
//   the chaining add. The input channel is not ready until the hasher is idle.
//   An end item pads one byte per cycle up to byte 56, writes the length,
//   then compresses; when the tail holds 56 or more bytes a second
//   compression follows.
// Reset: chaining words go to the SHA-1 initial values, the bit count to
//   zero, both channels idle. The same re-initialization follows each digest.
// Stall: the digest sits in an output register; new bytes are taken while
//   it waits. Only the next digest waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sha1s_pkg::in_item_t in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sha1s_pkg::out_item_t     out_item
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN
    } state_t;

    // what the current compression belongs to
    typedef enum logic [1:0] {
        PH_MSG,
        PH_PAD,
        PH_LAST
    } phase_t;

    state_t  state_reg,  state_next;
    phase_t  phase_reg,  phase_next;
    logic [6:0]  round_reg,  round_next;
    logic [5:0]  pos_reg,    pos_next;      // byte position in block
    logic        pad_first_reg, pad_first_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic        out_valid_reg, out_valid_next;

    // block buffer doubles as the message schedule window; word 0 at the MSBs
    logic [511:0] blk_reg, blk_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    sha1s_pkg::out_item_t out_item_reg, out_item_next;

    logic        in_acc;
    logic [31:0] w0, w2, w8, w13, w_new;
    logic [31:0] f_val, k_val, t_val;
    logic [31:0] sum [5];
    logic [7:0]  pad_byte;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // fixed schedule taps
    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                    (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

    // round function and constant
    always_comb
    begin
        priority if (round_reg < sha1s_pkg::ROUND_F1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1s_pkg::K0;
        end
        else if (round_reg < sha1s_pkg::ROUND_F2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1s_pkg::K1;
        end
        else if (round_reg < sha1s_pkg::ROUND_F3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1s_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1s_pkg::K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    assign sum[0] = chain_reg[0] + a_reg;
    assign sum[1] = chain_reg[1] + b_reg;
    assign sum[2] = chain_reg[2] + c_reg;
    assign sum[3] = chain_reg[3] + d_reg;
    assign sum[4] = chain_reg[4] + e_reg;

    assign pad_byte = pad_first_reg ? sha1s_pkg::PAD_MARK : 8'd0;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        pos_next       = pos_reg;
        pad_first_next = pad_first_reg;
        bit_len_next   = bit_len_reg;
        for (int i = 0; i < 5; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        blk_next       = blk_reg;
        // working vars track the chain outside of compression
        a_next = chain_reg[0];
        b_next = chain_reg[1];
        c_next = chain_reg[2];
        d_next = chain_reg[3];
        e_next = chain_reg[4];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_item.byte_present)
                    begin
                        blk_next     = {blk_reg[503:0], in_item.data_byte};
                        bit_len_next = bit_len_reg + 64'd8;
                        pos_next     = pos_reg + 6'd1;
                        if (pos_reg == sha1s_pkg::POS_LAST)
                        begin
                            state_next     = ST_ROUND;
                            round_next     = '0;
                            phase_next     = in_item.end_of_message ? PH_PAD : PH_MSG;
                            pad_first_next = 1'b1;
                        end
                        else if (in_item.end_of_message)
                        begin
                            state_next     = ST_PAD;
                            phase_next     = PH_PAD;
                            pad_first_next = 1'b1;
                        end
                    end
                    else if (in_item.end_of_message)
                    begin
                        state_next     = ST_PAD;
                        phase_next     = PH_PAD;
                        pad_first_next = 1'b1;
                    end
                end
            end

            ST_PAD:
            begin
                blk_next       = {blk_reg[503:0], pad_byte};
                pos_next       = pos_reg + 6'd1;
                pad_first_next = 1'b0;
                if (pos_reg == sha1s_pkg::POS_LAST)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                end
                else if (pos_reg == sha1s_pkg::POS_LEN_NEXT)
                begin
                    state_next = ST_LEN;
                end
            end

            ST_LEN:
            begin
                blk_next   = {blk_reg[447:0], bit_len_reg};
                pos_next   = '0;
                phase_next = PH_LAST;
                state_next = ST_ROUND;
                round_next = '0;
            end

            ST_ROUND:
            begin
                blk_next   = {blk_reg[479:0], w_new};
                a_next     = t_val;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 7'd1;
                if (round_reg == sha1s_pkg::ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                a_next = a_reg;
                b_next = b_reg;
                c_next = c_reg;
                d_next = d_reg;
                e_next = e_reg;
                unique case (phase_reg)
                    PH_MSG:
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            chain_next[i] = sum[i];
                        end
                        state_next = ST_IDLE;
                    end
                    PH_PAD:
                    begin
                        for (int i = 0; i < 5; i++)
                        begin
                            chain_next[i] = sum[i];
                        end
                        state_next = ST_PAD;
                    end
                    PH_LAST:
                    begin
                        // hold here until the output register is free
                        if (!out_valid_reg || out_ready)
                        begin
                            out_item_next.digest_word0 = sum[0];
                            out_item_next.digest_word1 = sum[1];
                            out_item_next.digest_word2 = sum[2];
                            out_item_next.digest_word3 = sum[3];
                            out_item_next.digest_word4 = sum[4];
                            out_valid_next = 1'b1;
                            chain_next[0]  = sha1s_pkg::H0;
                            chain_next[1]  = sha1s_pkg::H1;
                            chain_next[2]  = sha1s_pkg::H2;
                            chain_next[3]  = sha1s_pkg::H3;
                            chain_next[4]  = sha1s_pkg::H4;
                            bit_len_next   = '0;
                            pos_next       = '0;
                            phase_next     = PH_MSG;
                            state_next     = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, chaining words, length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_MSG;
            round_reg     <= '0;
            pos_reg       <= '0;
            pad_first_reg <= 1'b0;
            bit_len_reg   <= '0;
            out_valid_reg <= 1'b0;
            chain_reg[0]  <= sha1s_pkg::H0;
            chain_reg[1]  <= sha1s_pkg::H1;
            chain_reg[2]  <= sha1s_pkg::H2;
            chain_reg[3]  <= sha1s_pkg::H3;
            chain_reg[4]  <= sha1s_pkg::H4;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            pos_reg       <= pos_next;
            pad_first_reg <= pad_first_next;
            bit_len_reg   <= bit_len_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        e_reg        <= e_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire
